// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== design/aln_pkg.sv =====
// ----------------------------------------------------------------------------
// aln_pkg: shared types and constants
// Word layouts, record and error codes, the parse phase and the descriptor
// that travels from the front part to the back part of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aln_pkg;

    // Capacity of the output buffer in bytes.
    localparam int UNIT_BYTES = 65536;
    // Write pointer width: it can hold the capacity itself.
    localparam int WP_W = $clog2(UNIT_BYTES + 1);
    // Depth of the descriptor queue.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);
    // Highest NAL type that is kept.
    localparam logic [4:0] MAX_KEPT_TYPE = 5'd6;
    // Size of a length slot.
    localparam int SLOT_BYTES = 4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_LENGTH  = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_FORBIDDEN = 2'd1,
        ERR_NO_START  = 2'd2,
        ERR_OVERFLOW  = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        PH_SEEK   = 3'd0,
        PH_HEADER = 3'd1,
        PH_KEEP   = 3'd2,
        PH_SKIP   = 3'd3,
        PH_ERROR  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        t_kind       record_kind;
        logic [7:0]  out_byte;
        logic [15:0] write_address;
        logic [16:0] nal_length;
        logic [4:0]  nal_kind;
        t_err        error_code;
        logic        last_result;
    } t_out_word;

    // All records caused by one input byte, in a compact form.
    typedef struct packed {
        logic [2:0]      pay_n;     // payload records
        logic [1:0]      zeros;     // leading zero payloads
        logic [7:0]      data;      // byte after the zeros
        logic [WP_W-1:0] base;      // address of the first payload
        logic [4:0]      ptype;     // NAL type for the payloads
        t_err            err;       // error record after the payloads
        logic            len_v;     // length record present
        logic [15:0]     len_addr;
        logic [16:0]     len_val;
        logic [4:0]      len_type;
        logic            done_v;    // done record present
        logic [16:0]     total;
    } t_desc;

    // Push side of the descriptor queue.
    typedef struct packed {
        logic  push;
        t_desc desc;
    } t_push;

endpackage

`default_nettype wire

// ===== design/aln_front.sv =====
// ----------------------------------------------------------------------------
// aln_front: start code parser
// Accepts one byte a cycle unless the queue is full; tracks start codes, held
// zeros and buffer addresses; makes each byte one descriptor of its records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aln_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire aln_pkg::t_in_word i_word,
    input  wire logic              i_full,
    output aln_pkg::t_push         o_push
);

    localparam int WP_W = aln_pkg::WP_W;

    aln_pkg::t_phase   r_phase, n_phase, s_phase;
    logic [1:0]        r_held, n_held;
    logic [WP_W-1:0]   r_wp, n_wp, s_wp;
    logic [15:0]       r_slot, n_slot, s_slot;
    logic [16:0]       r_len, n_len, s_len;
    logic [4:0]        r_type, n_type, s_type;

    logic              accept;
    logic [7:0]        byte_v;
    logic              last;
    logic              start;
    logic              hdr_ovf;
    logic [2:0]        need;
    logic [2:0]        fit;
    logic              keep_ovf;
    aln_pkg::t_desc    d;

    assign accept = i_valid && !i_full;
    assign byte_v = i_word.data_byte;
    assign last   = i_word.last_byte;
    assign start  = (byte_v == 8'h01) && (r_held >= 2'd2);

    // A kept header needs its slot and its own byte below capacity.
    assign hdr_ovf = r_wp > WP_W'(aln_pkg::UNIT_BYTES - (aln_pkg::SLOT_BYTES + 1));

    // Payload bytes that still fit: the held zeros plus the byte itself.
    assign need = {1'b0, r_held} + 3'd1;
    always_comb begin
        fit = 3'd0;
        for (int k = 1; k <= 4; k++) begin
            if ((3'(k) <= need) && (r_wp <= WP_W'(aln_pkg::UNIT_BYTES - k))) begin
                fit = 3'(k);
            end
        end
    end
    assign keep_ovf = fit < need;

    // Phase after this byte, and the phase that the next byte sees.
    always_comb begin
        s_phase = r_phase;
        unique case (r_phase)
            aln_pkg::PH_SEEK: begin
                if (byte_v != 8'h00 && start) s_phase = aln_pkg::PH_HEADER;
            end
            aln_pkg::PH_HEADER: begin
                if (byte_v != 8'h00 && !start) begin
                    if (byte_v[7]) begin
                        s_phase = aln_pkg::PH_ERROR;
                    end else if (byte_v[4:0] <= aln_pkg::MAX_KEPT_TYPE) begin
                        s_phase = hdr_ovf ? aln_pkg::PH_ERROR : aln_pkg::PH_KEEP;
                    end else begin
                        s_phase = aln_pkg::PH_SKIP;
                    end
                end
            end
            aln_pkg::PH_KEEP: begin
                if (byte_v != 8'h00) begin
                    if (start) s_phase = aln_pkg::PH_HEADER;
                    else if (keep_ovf) s_phase = aln_pkg::PH_ERROR;
                end
            end
            aln_pkg::PH_SKIP: begin
                if (byte_v != 8'h00 && start) s_phase = aln_pkg::PH_HEADER;
            end
            aln_pkg::PH_ERROR: begin
                s_phase = aln_pkg::PH_ERROR;
            end
            default: begin
                s_phase = aln_pkg::PH_SEEK;
            end
        endcase
        n_phase = last ? aln_pkg::PH_SEEK : s_phase;
    end

    // Counters, addresses and the descriptor for this byte.
    always_comb begin
        n_held = r_held;
        s_wp   = r_wp;
        s_slot = r_slot;
        s_len  = r_len;
        s_type = r_type;
        d      = '0;
        d.err  = aln_pkg::ERR_NONE;

        if (r_phase != aln_pkg::PH_ERROR) begin
            if (byte_v == 8'h00) begin
                n_held = (r_held == 2'd3) ? r_held : r_held + 2'd1;
            end else begin
                n_held = 2'd0;
            end
        end

        unique case (r_phase)
            aln_pkg::PH_HEADER: begin
                if (byte_v != 8'h00 && !start) begin
                    if (byte_v[7]) begin
                        d.err = aln_pkg::ERR_FORBIDDEN;
                    end else begin
                        s_type = byte_v[4:0];
                        if (byte_v[4:0] <= aln_pkg::MAX_KEPT_TYPE) begin
                            if (hdr_ovf) begin
                                d.err = aln_pkg::ERR_OVERFLOW;
                            end else begin
                                s_slot  = 16'(r_wp);
                                s_wp    = r_wp + WP_W'(aln_pkg::SLOT_BYTES + 1);
                                s_len   = 17'd1;
                                d.pay_n = 3'd1;
                                d.data  = byte_v;
                                d.base  = r_wp + WP_W'(aln_pkg::SLOT_BYTES);
                                d.ptype = byte_v[4:0];
                            end
                        end
                    end
                end
            end
            aln_pkg::PH_KEEP: begin
                if (byte_v != 8'h00) begin
                    if (start) begin
                        d.len_v    = 1'b1;
                        d.len_addr = r_slot;
                        d.len_val  = r_len;
                        d.len_type = r_type;
                    end else begin
                        s_wp    = r_wp + WP_W'(fit);
                        s_len   = r_len + 17'(fit);
                        d.pay_n = fit;
                        d.zeros = r_held;
                        d.data  = byte_v;
                        d.base  = r_wp;
                        d.ptype = r_type;
                        if (keep_ovf) d.err = aln_pkg::ERR_OVERFLOW;
                    end
                end
            end
            aln_pkg::PH_SEEK, aln_pkg::PH_SKIP, aln_pkg::PH_ERROR: begin
            end
            default: begin
            end
        endcase

        // At unit end: close the NAL and report the total or a missing start.
        if (last) begin
            if (s_phase == aln_pkg::PH_SEEK) begin
                d.err = aln_pkg::ERR_NO_START;
            end else if (s_phase != aln_pkg::PH_ERROR) begin
                if (s_phase == aln_pkg::PH_KEEP) begin
                    d.len_v    = 1'b1;
                    d.len_addr = s_slot;
                    d.len_val  = s_len;
                    d.len_type = s_type;
                end
                d.done_v = 1'b1;
                d.total  = 17'(s_wp);
            end
            n_held = 2'd0;
            n_wp   = '0;
            n_slot = '0;
            n_len  = '0;
            n_type = '0;
        end else begin
            n_wp   = s_wp;
            n_slot = s_slot;
            n_len  = s_len;
            n_type = s_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= aln_pkg::PH_SEEK;
            r_held  <= '0;
            r_wp    <= '0;
            r_slot  <= '0;
            r_len   <= '0;
            r_type  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_wp    <= n_wp;
            r_slot  <= n_slot;
            r_len   <= n_len;
            r_type  <= n_type;
        end
    end

    // Only bytes that cause a record enter the queue.
    assign o_push.push = accept && ((d.pay_n != 3'd0) || (d.err != aln_pkg::ERR_NONE)
                                    || d.len_v || d.done_v);
    assign o_push.desc = d;

endmodule

`default_nettype wire

// ===== design/aln_fifo.sv =====
// ----------------------------------------------------------------------------
// aln_fifo: descriptor queue
// A short queue that lets the parser run ahead while records drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aln_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire aln_pkg::t_push i_push,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_avail,
    output aln_pkg::t_desc      o_head
);

    localparam int AW = aln_pkg::Q_AW;

    aln_pkg::t_desc    r_mem [aln_pkg::Q_DEPTH];
    logic [AW-1:0]     r_wr, r_rd;
    logic [AW:0]       r_cnt, n_cnt;
    logic              do_pop;

    assign o_full  = r_cnt == (AW + 1)'(aln_pkg::Q_DEPTH);
    assign o_avail = r_cnt != '0;
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && o_avail;

    // Occupancy follows pushes and pops.
    always_comb begin
        n_cnt = r_cnt;
        if (i_push.push && !do_pop) n_cnt = r_cnt + 1'b1;
        else if (!i_push.push && do_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push.push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.push) r_mem[r_wr] <= i_push.desc;
    end

endmodule

`default_nettype wire

// ===== design/aln_back.sv =====
// ----------------------------------------------------------------------------
// aln_back: record sequencer
// Expands the descriptor at the head of the queue into output words,
// one a cycle unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aln_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_avail,
    input  wire aln_pkg::t_desc i_head,
    output logic                o_pop,
    output logic                o_valid,
    output aln_pkg::t_out_word  o_word,
    input  wire logic           i_stall
);

    localparam int WP_W = aln_pkg::WP_W;

    logic [2:0]          r_j, n_j;
    logic                r_ov;
    aln_pkg::t_out_word  r_word;
    aln_pkg::t_out_word  rec;
    logic [2:0]          total;
    logic [2:0]          err_pos;
    logic                err_v;
    logic                load;
    logic                is_last;

    assign err_v   = i_head.err != aln_pkg::ERR_NONE;
    assign total   = i_head.pay_n + 3'(err_v) + 3'(i_head.len_v) + 3'(i_head.done_v);
    assign err_pos = i_head.pay_n + 3'(err_v);
    assign is_last = r_j == (total - 3'd1);
    assign load    = i_avail && (!r_ov || !i_stall);
    assign o_pop   = load && is_last;
    assign n_j     = is_last ? 3'd0 : r_j + 3'd1;

    // Record at the current position: payloads, error, length, done.
    always_comb begin
        rec            = '0;
        rec.error_code = aln_pkg::ERR_NONE;
        rec.last_result = is_last;
        priority if (r_j < i_head.pay_n) begin
            rec.record_kind   = aln_pkg::KIND_PAYLOAD;
            rec.out_byte      = ({1'b0, r_j} < {2'b00, i_head.zeros}) ? 8'h00 : i_head.data;
            rec.write_address = 16'(i_head.base + WP_W'(r_j));
            rec.nal_kind      = i_head.ptype;
        end else if (err_v && r_j == i_head.pay_n) begin
            rec.record_kind = aln_pkg::KIND_ERROR;
            rec.error_code  = i_head.err;
        end else if (i_head.len_v && r_j == err_pos) begin
            rec.record_kind   = aln_pkg::KIND_LENGTH;
            rec.write_address = i_head.len_addr;
            rec.nal_length    = i_head.len_val;
            rec.nal_kind      = i_head.len_type;
        end else begin
            rec.record_kind = aln_pkg::KIND_DONE;
            rec.nal_length  = i_head.total;
        end
    end

    // Output stage and position counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_j  <= '0;
        end else if (load) begin
            r_ov <= 1'b1;
            r_j  <= n_j;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_word <= rec;
    end

    assign o_valid = r_ov;
    assign o_word  = r_word;

endmodule

`default_nettype wire

// ===== design/annexb_to_length_prefixed_nal_unit.sv =====
// ----------------------------------------------------------------------------
// annexb_to_length_prefixed_nal_unit: Annex B to length-prefixed NAL converter
// Parses an access unit byte by byte and emits buffer write records.
// ----------------------------------------------------------------------------
// The block takes one access unit byte per cycle unless the input stalls. A
// byte that causes at most one record passes at that rate; a byte that causes
// several (held zeros released, a closing length record and the done record)
// keeps the record sequencer busy for its records in turn, up to six. The
// parser and the sequencer are joined by a four-entry descriptor queue, so
// the input stalls only once four bursts are waiting; sustained throughput is
// set by the sequencer's one record a cycle while the output is not stalled.
// Results leave a registered output stage. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module annexb_to_length_prefixed_nal_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire aln_pkg::t_in_word  i_in_word,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output aln_pkg::t_out_word      o_out_word,
    input  wire logic               i_out_stall
);

    aln_pkg::t_push  push;
    aln_pkg::t_desc  head;
    logic            full;
    logic            avail;
    logic            pop;

    assign o_in_stall = full;

    // Parser: classifies each word.
    aln_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .i_full  (full),
        .o_push  (push)
    );

    // Queue between parser and sequencer.
    aln_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_avail (avail),
        .o_head  (head)
    );

    // Sequencer: one output word a cycle unless the output stalls.
    aln_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .i_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ===== design/aln_checker.sv =====
// ----------------------------------------------------------------------------
// aln_checker: port-level checks
// Watches the top level's ports and checks record framing over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module aln_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire aln_pkg::t_out_word o_out_word,
    input wire logic               i_out_stall
);

    // A stalled output word stays offered and unchanged.
    `ASSERT_AT(a_hold_valid, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid,
        "output word withdrawn under stall")
    `ASSERT_AT(a_hold_word, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> $stable(o_out_word),
        "output word changed under stall")

    // Error and done records always close the burst of their byte.
    `ASSERT_AT(a_err_last, i_clk, i_rst_n,
        o_out_valid && o_out_word.record_kind == aln_pkg::KIND_ERROR
            |-> o_out_word.last_result && o_out_word.error_code != aln_pkg::ERR_NONE,
        "bad error record")
    `ASSERT_AT(a_done_last, i_clk, i_rst_n,
        o_out_valid && o_out_word.record_kind == aln_pkg::KIND_DONE
            |-> o_out_word.last_result && o_out_word.error_code == aln_pkg::ERR_NONE,
        "bad done record")

    // Only payload records carry a data byte.
    `ASSERT_NEVER(a_byte_zero, i_clk, i_rst_n,
        o_out_valid && o_out_word.record_kind != aln_pkg::KIND_PAYLOAD
            && o_out_word.out_byte != 8'h00,
        "byte on a non-payload record")

endmodule

bind annexb_to_length_prefixed_nal_unit aln_checker u_aln_checker (.*);

`default_nettype wire
